// ----- hdl/owm_pkg.sv -----
// Shared types, constants and helpers for the 1-Wire bus master.
`default_nettype none
package owm_pkg;

  // Timer and strobe sizing
  localparam int unsigned TIMER_BITS     = 10;
  localparam int unsigned READ_LOW_TICKS = 2;
  localparam int unsigned CFG_BITS       = 10;
  localparam int unsigned CFG_IDX_BITS   = 3;

  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  // Command codes of the input beat
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRES_SAMPLE   = 3'd1,
    CFG_RESET_RECOV   = 3'd2,
    CFG_ONE_LOW       = 3'd3,
    CFG_ZERO_LOW      = 3'd4,
    CFG_WRITE_SLOT    = 3'd5,
    CFG_READ_SAMPLE   = 3'd6,
    CFG_READ_SLOT     = 3'd7
  } owm_cfg_idx_e;

  // Classified item kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } owm_kind_e;

  // Input beat payload
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] write_data;
    logic       bus_level;
  } owm_in_t;

  // Result beat payload
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic       bus_stuck;
    logic [7:0] read_data;
  } owm_out_t;

  // Item passed from front to back through the queue
  typedef struct packed {
    owm_kind_e  kind;
    logic [7:0] write_data;
    logic       bus_level;
  } owm_item_t;

  // Timing registers, already clamped to the timer range
  typedef struct packed {
    logic [TIMER_BITS-1:0] reset_low;
    logic [TIMER_BITS-1:0] pres_sample;
    logic [TIMER_BITS-1:0] reset_recov;
    logic [TIMER_BITS-1:0] one_low;
    logic [TIMER_BITS-1:0] zero_low;
    logic [TIMER_BITS-1:0] write_slot;
    logic [TIMER_BITS-1:0] read_sample;
    logic [TIMER_BITS-1:0] read_slot;
  } owm_cfg_t;

  // Clamp a register value: zero acts as one, above the timer acts as the maximum
  function automatic logic [TIMER_BITS-1:0] owm_lim(input logic [CFG_BITS-1:0] v);
    logic [TIMER_BITS-1:0] r;
    if (v == '0) begin
      r = TIMER_BITS'(1);
    end else if (32'(v) > 32'(TMAX)) begin
      r = TMAX;
    end else begin
      r = TIMER_BITS'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/owm_front.sv -----
// Input stage: accepts command beats and classifies them into queue items.
`default_nettype none
module owm_front import owm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire owm_in_t   in_data_i,
  output logic           item_valid_o,
  output owm_item_t      item_o,
  input  wire logic      item_ready_i
);

  logic      valid_q, valid_d;
  owm_item_t item_q, item_d;
  owm_kind_e kind;
  logic      take;

  // Classify the command code
  always_comb begin
    unique case (in_data_i.cmd)
      CMD_TICK:  kind = KIND_TICK;
      CMD_RESET: kind = KIND_RESET;
      CMD_WRITE: kind = KIND_WRITE;
      CMD_READ:  kind = KIND_READ;
      default:   kind = KIND_TICK;
    endcase
  end

  // Take a new beat when the holding register is empty or drains this cycle
  assign take       = !valid_q || item_ready_i;
  assign in_stall_o = !take;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        item_d.kind       = kind;
        item_d.write_data = in_data_i.write_data;
        item_d.bus_level  = in_data_i.bus_level;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

// ----- hdl/owm_queue.sv -----
// Two-entry queue between the classifying front and the executing back.
`default_nettype none
module owm_queue import owm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire owm_item_t push_item_i,
  output logic           pop_valid_o,
  input  wire logic      pop_i,
  output owm_item_t      pop_item_o
);

  owm_item_t   mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/owm_back.sv -----
// Execution stage: bus timing state machine and registered result beat.
`default_nettype none
module owm_back import owm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire owm_cfg_t  cfg_i,
  input  wire logic      item_valid_i,
  output logic           item_pop_o,
  input  wire owm_item_t item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output owm_out_t       out_data_o
);

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_RLOW  = 6'b000010,
    PH_RWAIT = 6'b000100,
    PH_RREC  = 6'b001000,
    PH_WR    = 6'b010000,
    PH_RD    = 6'b100000
  } owm_phase_e;

  owm_phase_e            phase_q, phase_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [2:0]            bit_q, bit_d;
  logic [7:0]            shift_q, shift_d;
  logic                  pres_q, pres_d;
  logic                  stuck_q, stuck_d;
  logic [7:0]            last_q, last_d;
  logic                  done;

  logic                  out_valid_q;
  owm_out_t              out_q, out_d;

  logic                  pop;
  logic [TIMER_BITS-1:0] tinc;
  logic [TIMER_BITS-1:0] samp;
  logic [TIMER_BITS-1:0] low_len;
  logic [7:0]            shift_rd;
  logic                  drive;

  // Pop an item whenever the result register is free or being drained
  assign pop        = item_valid_i && (!out_valid_q || !out_stall_i);
  assign item_pop_o = pop;

  assign tinc     = (timer_q < TMAX) ? timer_q + TIMER_BITS'(1) : timer_q;
  assign samp     = (cfg_i.read_sample > cfg_i.read_slot) ? cfg_i.read_slot : cfg_i.read_sample;
  assign shift_rd = (tinc == samp) ? {item_i.bus_level, shift_q[7:1]} : shift_q;

  // Next state for the popped item
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    stuck_d = stuck_q;
    last_d  = last_q;
    done    = 1'b0;
    if (pop) begin
      if (phase_q == PH_IDLE) begin
        unique case (item_i.kind)
          KIND_RESET: begin
            pres_d = 1'b0;
            if (!item_i.bus_level) begin
              stuck_d = 1'b1;
              done    = 1'b1;
            end else begin
              stuck_d = 1'b0;
              phase_d = PH_RLOW;
              timer_d = '0;
            end
          end
          KIND_WRITE: begin
            phase_d = PH_WR;
            shift_d = item_i.write_data;
            timer_d = '0;
            bit_d   = 3'd0;
          end
          KIND_READ: begin
            phase_d = PH_RD;
            shift_d = 8'd0;
            timer_d = '0;
            bit_d   = 3'd0;
          end
          default: begin
          end
        endcase
      end else if (item_i.kind == KIND_TICK) begin
        timer_d = tinc;
        unique case (phase_q)
          PH_RLOW: begin
            if (tinc >= cfg_i.reset_low) begin
              phase_d = PH_RWAIT;
              timer_d = '0;
            end
          end
          PH_RWAIT: begin
            if (tinc >= cfg_i.pres_sample) begin
              pres_d  = !item_i.bus_level;
              phase_d = PH_RREC;
              timer_d = '0;
            end
          end
          PH_RREC: begin
            if (tinc >= cfg_i.reset_recov) begin
              phase_d = PH_IDLE;
              timer_d = '0;
              done    = 1'b1;
            end
          end
          PH_WR: begin
            if (tinc >= cfg_i.write_slot) begin
              timer_d = '0;
              shift_d = {1'b0, shift_q[7:1]};
              bit_d   = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
          end
          PH_RD: begin
            shift_d = shift_rd;
            if (tinc >= cfg_i.read_slot) begin
              timer_d = '0;
              bit_d   = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                last_d  = shift_rd;
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
            timer_d = '0;
          end
        endcase
      end
    end
  end

  // Drive level seen after the item is handled
  assign low_len = shift_d[0] ? cfg_i.one_low : cfg_i.zero_low;
  always_comb begin
    unique case (phase_d)
      PH_RLOW: drive = 1'b1;
      PH_WR:   drive = (timer_d < low_len);
      PH_RD:   drive = (timer_d < TIMER_BITS'(READ_LOW_TICKS));
      default: drive = 1'b0;
    endcase
  end

  always_comb begin
    out_d.drive_low = drive;
    out_d.busy_res  = (phase_d != PH_IDLE);
    out_d.done_res  = done;
    out_d.presence  = pres_d;
    out_d.bus_stuck = stuck_d;
    out_d.read_data = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      timer_q     <= '0;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      pres_q      <= 1'b0;
      stuck_q     <= 1'b0;
      last_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      pres_q      <= pres_d;
      stuck_q     <= stuck_d;
      last_q      <= last_d;
      out_valid_q <= pop || (out_valid_q && out_stall_i);
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ----- hdl/onewire_bus_master.sv -----
// Path: an accepted input beat passes through the front holding register, the queue and the result register.
// Throughput: one item per cycle while the result output is not stalled.
// Every item, tick or command, yields exactly one result beat.
// Reset: asynchronous, active low; bus idle, flags and timers cleared,
// timing registers back to their default values.
`default_nettype none
module onewire_bus_master import owm_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire owm_in_t                 in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output owm_out_t                     out_data_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_BITS-1:0]     cfg_data_i
);

  owm_cfg_t  cfg_q, cfg_d;
  logic      f_valid, f_ready;
  owm_item_t f_item;
  logic      q_valid, q_pop;
  owm_item_t q_item;
  logic      cfg_wr;

  // Timing registers, stored already clamped
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (owm_cfg_idx_e'(cfg_index_i))
        CFG_RESET_LOW:   cfg_d.reset_low   = owm_lim(cfg_data_i);
        CFG_PRES_SAMPLE: cfg_d.pres_sample = owm_lim(cfg_data_i);
        CFG_RESET_RECOV: cfg_d.reset_recov = owm_lim(cfg_data_i);
        CFG_ONE_LOW:     cfg_d.one_low     = owm_lim(cfg_data_i);
        CFG_ZERO_LOW:    cfg_d.zero_low    = owm_lim(cfg_data_i);
        CFG_WRITE_SLOT:  cfg_d.write_slot  = owm_lim(cfg_data_i);
        CFG_READ_SAMPLE: cfg_d.read_sample = owm_lim(cfg_data_i);
        CFG_READ_SLOT:   cfg_d.read_slot   = owm_lim(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low   <= owm_lim(CFG_BITS'(480));
      cfg_q.pres_sample <= owm_lim(CFG_BITS'(70));
      cfg_q.reset_recov <= owm_lim(CFG_BITS'(410));
      cfg_q.one_low     <= owm_lim(CFG_BITS'(6));
      cfg_q.zero_low    <= owm_lim(CFG_BITS'(60));
      cfg_q.write_slot  <= owm_lim(CFG_BITS'(70));
      cfg_q.read_sample <= owm_lim(CFG_BITS'(10));
      cfg_q.read_slot   <= owm_lim(CFG_BITS'(63));
    end else begin
      cfg_q <= cfg_d;
    end
  end

  owm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (f_valid),
    .item_o       (f_item),
    .item_ready_i (f_ready)
  );

  owm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_item_o   (q_item)
  );

  owm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_pop_o   (q_pop),
    .item_i       (q_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire
